[rtl/mmd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared widths, constants and types of the magnetorquer momentum-dump core.
// ----------------------------------------------------------------------------
package mmd_pkg;

  // Field widths.
  localparam int AXES      = 3;
  localparam int SPEED_W   = 32;
  localparam int FIELD_W   = 18;
  localparam int TORQUE_W  = 32;
  localparam int DIPOLE_W  = 18;
  localparam int GAIN_W    = 24;
  localparam int TGT_W     = 31;
  localparam int LIM_W     = 17;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  // Dipole divider: quotient bits that can fall below the clamp limit.
  localparam int QBITS     = LIM_W;
  localparam int BSQ_W     = 36;
  localparam int DEN_SHIFT = 11;
  localparam int RND_SHIFT = 10;
  localparam int DEN_W     = BSQ_W + DEN_SHIFT;
  localparam int REM_W     = DEN_W + QBITS;
  localparam int NUM_W     = 80;
  localparam int DIV_LAT   = QBITS + 1;

  // Torque scaling by 2048 / 1953125 through a reciprocal.
  localparam int Y_W         = 48;
  localparam int Y_HALF      = 24;
  localparam int QT_W        = 27;
  localparam int RECIP_SHIFT = 48;
  localparam int SCALE_LAT   = 4;

  localparam logic [20:0] CONV_NUM   = 21'd1953125;
  localparam logic [27:0] RECIP      = 28'd144115188;
  localparam logic [19:0] ROUND_HALF = 20'd976562;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RST = 24'd494780;
  localparam logic [TGT_W-1:0]  TGT_RST  = 31'd6862979;
  localparam logic [LIM_W-1:0]  LIM_RST  = 17'd112692;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUMP_GAIN    = 2'd0,
    CFG_TARGET_SPEED = 2'd1,
    CFG_DIPOLE_LIMIT = 2'd2
  } cfg_idx_t;

  // Divider lane result: overflow past the clamp range and the quotient.
  typedef struct packed {
    logic             ovf;
    logic [QBITS-1:0] q;
  } div_res_t;

  // Side data that rides along with the divider lanes.
  typedef struct packed {
    logic [AXES-1:0][FIELD_W-1:0] b;
    logic [AXES-1:0]              cneg;
    logic                         gated;
    logic                         fz;
  } div_side_t;

  // Side data that rides along with the torque stages.
  typedef struct packed {
    logic [AXES-1:0][DIPOLE_W-1:0] m;
    logic                          gated;
    logic                          fz;
  } out_side_t;

endpackage
`default_nettype wire

[rtl/mmd_dipole_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_dipole_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// check for quotients that reach past the dipole clamp range.
// ----------------------------------------------------------------------------
module mmd_dipole_div (
  input  logic                       clk,
  input  logic [mmd_pkg::NUM_W-1:0]  num,
  input  logic [mmd_pkg::DEN_W-1:0]  den,
  output mmd_pkg::div_res_t          res
);
  import mmd_pkg::*;

  logic [REM_W-1:0] rem_r [QBITS+1];
  logic [DEN_W-1:0] den_r [QBITS+1];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             ovf_r [QBITS+1];
  logic             ovf_nxt;

  // First stage: a quotient of 2^QBITS or more saturates at the clamp.
  assign ovf_nxt = (num >= NUM_W'({den, {QBITS{1'b0}}}));

  always_ff @(posedge clk) begin
    rem_r[0] <= num[REM_W-1:0];
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= ovf_nxt;
  end

  // One compare and subtract per stage, most significant bit first.
  for (genvar s = 1; s <= QBITS; s++) begin : g_stage
    localparam int K = QBITS - s;
    logic [REM_W-1:0] trial;
    logic             take;

    assign trial = REM_W'(den_r[s-1]) << K;
    assign take  = (rem_r[s-1] >= trial);

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? (rem_r[s-1] - trial) : rem_r[s-1];
      den_r[s] <= den_r[s-1];
      q_r[s]   <= q_r[s-1] | (QBITS'(take) << K);
      ovf_r[s] <= ovf_r[s-1];
    end
  end

  assign res.ovf = ovf_r[QBITS];
  assign res.q   = q_r[QBITS];

endmodule
`default_nettype wire

[rtl/mmd_torque_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_torque_scale
// Divides by 1953125 through a 48-bit reciprocal product and one
// correction step, over four stages.
// ----------------------------------------------------------------------------
module mmd_torque_scale (
  input  logic                     clk,
  input  logic [mmd_pkg::Y_W-1:0]  y,
  output logic [mmd_pkg::QT_W-1:0] q
);
  import mmd_pkg::*;

  logic [51:0]     pl_r, ph_r;
  logic [Y_W-1:0]  y1_r, y2_r, y3_r;
  logic [75:0]     sum;
  logic [QT_W-1:0] q0_r, q03_r;
  logic [Y_W-1:0]  prod_r;
  logic [Y_W-1:0]  rem;
  logic [QT_W-1:0] q_r;

  // Partial products of the reciprocal multiply.
  always_ff @(posedge clk) begin
    pl_r <= y[Y_HALF-1:0] * RECIP;
    ph_r <= y[Y_W-1:Y_HALF] * RECIP;
    y1_r <= y;
  end

  // Estimate, low by at most one.
  assign sum = {ph_r, {Y_HALF{1'b0}}} + 76'(pl_r);

  always_ff @(posedge clk) begin
    q0_r <= sum[RECIP_SHIFT +: QT_W];
    y2_r <= y1_r;
  end

  // Back-multiply the estimate.
  always_ff @(posedge clk) begin
    prod_r <= q0_r * CONV_NUM;
    q03_r  <= q0_r;
    y3_r   <= y2_r;
  end

  // Correct the estimate by one where the remainder allows.
  assign rem = y3_r - prod_r;

  always_ff @(posedge clk) begin
    q_r <= (rem >= Y_W'(CONV_NUM)) ? (q03_r + 1'b1) : q03_r;
  end

  assign q = q_r;

endmodule
`default_nettype wire

[rtl/magnetorquer_momentum_dump_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetorquer_momentum_dump_core
// Momentum-dump law for magnetorquers: desired torque from wheel speed
// excess, dipole m = (B x tau) / |B|^2 with an opposing-torque gate,
// per-axis clamp, and the resulting torque m x B.
//
//  Channel   Handshake            Beat contents
//  --------  -------------------  --------------------------------------------
//  input     start / busy         three wheel speeds, three field components
//  result    out_valid strobe     three torques, three dipoles, two flags
//  config    cfg_we               register index and data, no wait
//
//  A beat is taken in every cycle outside reset; results leave one per
//  input beat, in order, after the 18-stage dipole divider (an overflow
//  check, then one quotient bit per stage) and the cross-product,
//  rounding and torque-scaling stages.
//  Reset is synchronous and clears the valid line and the configuration
//  registers to their defaults; busy is high only while reset is held.
//  The result strobe cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module magnetorquer_momentum_dump_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [mmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmd_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [mmd_pkg::SPEED_W-1:0]  in_wheel_speed_x,
  input  logic signed [mmd_pkg::SPEED_W-1:0]  in_wheel_speed_y,
  input  logic signed [mmd_pkg::SPEED_W-1:0]  in_wheel_speed_z,
  input  logic signed [mmd_pkg::FIELD_W-1:0]  in_field_x,
  input  logic signed [mmd_pkg::FIELD_W-1:0]  in_field_y,
  input  logic signed [mmd_pkg::FIELD_W-1:0]  in_field_z,
  output logic                                out_valid,
  output logic signed [mmd_pkg::TORQUE_W-1:0] out_torque_x,
  output logic signed [mmd_pkg::TORQUE_W-1:0] out_torque_y,
  output logic signed [mmd_pkg::TORQUE_W-1:0] out_torque_z,
  output logic signed [mmd_pkg::DIPOLE_W-1:0] out_dipole_x,
  output logic signed [mmd_pkg::DIPOLE_W-1:0] out_dipole_y,
  output logic signed [mmd_pkg::DIPOLE_W-1:0] out_dipole_z,
  output logic                                out_gated_off,
  output logic                                out_field_zero
);
  import mmd_pkg::*;

  localparam int TAIL_LAT = 3 + SCALE_LAT;
  localparam int LAT      = 8 + DIV_LAT + 1 + TAIL_LAT + 1;

  // Configuration registers.
  logic [GAIN_W-1:0] dump_gain_r;
  logic [TGT_W-1:0]  target_speed_r;
  logic [LIM_W-1:0]  dipole_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dump_gain_r    <= GAIN_RST;
      target_speed_r <= TGT_RST;
      dipole_limit_r <= LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DUMP_GAIN:    dump_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_TARGET_SPEED: target_speed_r <= cfg_data[TGT_W-1:0];
        CFG_DIPOLE_LIMIT: dipole_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid line that travels with the data.
  logic           accept;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign busy    = ~rst_n;
  assign accept  = start & ~busy;
  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  logic signed [SPEED_W-1:0] w_in [AXES];
  logic signed [FIELD_W-1:0] b_in [AXES];

  assign w_in[0] = in_wheel_speed_x;
  assign w_in[1] = in_wheel_speed_y;
  assign w_in[2] = in_wheel_speed_z;
  assign b_in[0] = in_field_x;
  assign b_in[1] = in_field_y;
  assign b_in[2] = in_field_z;

  // Stage registers.
  logic [31:0]               emag_r   [AXES];
  logic [34:0]               sq_r     [AXES];
  logic signed [FIELD_W-1:0] b1_r     [AXES];
  logic [AXES-1:0]           tn1_r;
  logic [55:0]               prod_r   [AXES];
  logic signed [FIELD_W-1:0] b2_r     [AXES];
  logic [AXES-1:0]           tn2_r;
  logic [BSQ_W-1:0]          bsq2_r, bsq3_r, bsq4_r, bsq5_r, bsq6_r, bsq7_r, bsq8_r;
  logic signed [39:0]        tau_r    [AXES];
  logic signed [FIELD_W-1:0] b3_r [AXES], b4_r [AXES], b5_r [AXES];
  logic signed [FIELD_W-1:0] b6_r [AXES], b7_r [AXES], b8_r [AXES];
  logic                      fz3_r, fz4_r, fz5_r, fz6_r, fz7_r, fz8_r;
  logic signed [57:0]        ca_r [AXES], cb_r [AXES];
  logic [AXES-1:0]           tp4_r, tn4_r, tp5_r, tn5_r, tp6_r, tn6_r, tp7_r, tn7_r;
  logic signed [58:0]        c_r [AXES];
  logic signed [47:0]        dha_r [AXES], dhb_r [AXES], dla_r [AXES], dlb_r [AXES];
  logic signed [51:0]        cdh_r [AXES], cdl_r [AXES];
  logic [AXES-1:0]           cn6_r, cn7_r, cn8_r;
  logic signed [78:0]        d_r  [AXES];
  logic signed [80:0]        cd_r [AXES];
  logic [NUM_W-1:0]          num_r [AXES];
  logic                      gated8_r;
  logic [AXES-1:0]           gv;
  logic                      gated_nxt;

  // Divider and torque-side signals.
  div_res_t                  dres [AXES];
  div_side_t                 dside_r [DIV_LAT];
  div_side_t                 dside_nxt;
  out_side_t                 sm_r, sm_nxt;
  logic signed [FIELD_W-1:0] bm_r [AXES];
  out_side_t                 tail_r [TAIL_LAT];
  logic signed [35:0]        ta_r [AXES], tb_r [AXES];
  logic signed [36:0]        t_r  [AXES];
  logic [Y_W-1:0]            y_r  [AXES];
  logic [AXES-1:0]           ts3_r;
  logic [AXES-1:0]           tsd_r [SCALE_LAT];
  logic [QT_W-1:0]           tq   [AXES];
  logic signed [TORQUE_W-1:0] torque_r [AXES];

  // Sum of the field squares, |B|^2, with the side flags delayed alongside.
  always_ff @(posedge clk) begin
    bsq2_r <= BSQ_W'(sq_r[0]) + BSQ_W'(sq_r[1]) + BSQ_W'(sq_r[2]);
    tn2_r  <= tn1_r;
    bsq3_r <= bsq2_r;
    fz3_r  <= (bsq2_r == '0);
    bsq4_r <= bsq3_r;
    fz4_r  <= fz3_r;
    bsq5_r <= bsq4_r;
    fz5_r  <= fz4_r;
    tp5_r  <= tp4_r;
    tn5_r  <= tn4_r;
    bsq6_r <= bsq5_r;
    fz6_r  <= fz5_r;
    tp6_r  <= tp5_r;
    tn6_r  <= tn5_r;
    bsq7_r <= bsq6_r;
    fz7_r  <= fz6_r;
    tp7_r  <= tp6_r;
    tn7_r  <= tn6_r;
    cn7_r  <= cn6_r;
    bsq8_r <= bsq7_r;
    fz8_r  <= fz7_r;
    cn8_r  <= cn7_r;
    gated8_r <= gated_nxt;
  end

  assign gated_nxt = |gv;

  for (genvar a = 0; a < AXES; a++) begin : g_ax
    localparam int J = (a + 1) % AXES;
    localparam int K = (a + 2) % AXES;

    logic signed [32:0]       ws, tg, e;
    logic signed [35:0]       sqf;
    logic [31:0]              emag_nxt;
    logic [56:0]              rnd;
    logic [38:0]              mg;
    logic signed [39:0]       tau_nxt;
    logic signed [57:0]       ca_nxt, cb_nxt;
    logic signed [29:0]       ch_j, ch_k, cl_j, cl_k, ch_a, cl_a;
    logic signed [21:0]       kd;
    logic signed [48:0]       dh, dl;
    logic signed [78:0]       dhx, dlx;
    logic signed [80:0]       cdhx, cdlx, cabs;
    logic [LIM_W-1:0]         qsel, mm;
    logic signed [36:0]       t_nxt;
    logic [35:0]              tmag;

    // Stage 1: speed excess over the target, and field squares.
    assign ws  = w_in[a];
    assign tg  = $signed({2'b00, target_speed_r});
    assign e   = (ws > 0) ? (ws - tg) : (ws + tg);
    assign sqf = b_in[a] * b_in[a];
    assign emag_nxt = (w_in[a] == '0) ? '0 : ((e < 0) ? 32'(-e) : 32'(e));

    always_ff @(posedge clk) begin
      emag_r[a] <= emag_nxt;
      tn1_r[a]  <= (e > 0);
      sq_r[a]   <= sqf[34:0];
      b1_r[a]   <= b_in[a];
    end

    // Stage 2: gain times excess.
    always_ff @(posedge clk) begin
      prod_r[a] <= dump_gain_r * emag_r[a];
      b2_r[a]   <= b1_r[a];
    end

    // Stage 3: round half away from zero and apply the sign.
    assign rnd     = {1'b0, prod_r[a]} + 57'd32768;
    assign mg      = rnd[54:16];
    assign tau_nxt = tn2_r[a] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});

    always_ff @(posedge clk) begin
      tau_r[a] <= tau_nxt;
      b3_r[a]  <= b2_r[a];
    end

    // Stage 4: cross-product terms of B x tau.
    assign ca_nxt = b3_r[J] * tau_r[K];
    assign cb_nxt = b3_r[K] * tau_r[J];

    always_ff @(posedge clk) begin
      ca_r[a]  <= ca_nxt;
      cb_r[a]  <= cb_nxt;
      tp4_r[a] <= (tau_r[a] > 0);
      tn4_r[a] <= (tau_r[a] < 0);
      b4_r[a]  <= b3_r[a];
    end

    // Stage 5: c = B x tau.
    always_ff @(posedge clk) begin
      c_r[a]  <= 59'(ca_r[a]) - 59'(cb_r[a]);
      b5_r[a] <= b4_r[a];
    end

    // Stage 6: split c into halves for the check and numerator products.
    assign ch_a = $signed(c_r[a][58:29]);
    assign cl_a = $signed({1'b0, c_r[a][28:0]});
    assign ch_j = $signed(c_r[J][58:29]);
    assign cl_j = $signed({1'b0, c_r[J][28:0]});
    assign ch_k = $signed(c_r[K][58:29]);
    assign cl_k = $signed({1'b0, c_r[K][28:0]});
    assign kd   = $signed({1'b0, CONV_NUM});

    always_ff @(posedge clk) begin
      dha_r[a] <= ch_j * b5_r[K];
      dhb_r[a] <= ch_k * b5_r[J];
      dla_r[a] <= cl_j * b5_r[K];
      dlb_r[a] <= cl_k * b5_r[J];
      cdh_r[a] <= ch_a * kd;
      cdl_r[a] <= cl_a * kd;
      cn6_r[a] <= (c_r[a] < 0);
      b6_r[a]  <= b5_r[a];
    end

    // Stage 7: d = (c x B), which is tau*|B|^2 - B*(B.tau), and c*1953125.
    assign dh   = dha_r[a] - dhb_r[a];
    assign dl   = dla_r[a] - dlb_r[a];
    assign dhx  = dh;
    assign dlx  = dl;
    assign cdhx = cdh_r[a];
    assign cdlx = cdl_r[a];

    always_ff @(posedge clk) begin
      d_r[a]  <= (dhx <<< 29) + dlx;
      cd_r[a] <= (cdhx <<< 29) + cdlx;
      b7_r[a] <= b6_r[a];
    end

    // Stage 8: rounded numerator and the opposing-torque check.
    assign cabs  = (cd_r[a] < 0) ? -cd_r[a] : cd_r[a];
    assign gv[a] = (tp7_r[a] && (d_r[a] < 0)) || (tn7_r[a] && (d_r[a] > 0));

    always_ff @(posedge clk) begin
      num_r[a] <= cabs[NUM_W-1:0] + (NUM_W'(bsq7_r) << RND_SHIFT);
      b8_r[a]  <= b7_r[a];
    end

    mmd_dipole_div u_div (
      .clk (clk),
      .num (num_r[a]),
      .den ({bsq8_r, {DEN_SHIFT{1'b0}}}),
      .res (dres[a])
    );

    assign dside_nxt.b[a]    = b8_r[a];
    assign dside_nxt.cneg[a] = cn8_r[a];

    // Clamp, gate and sign the dipole.
    assign qsel = (dres[a].ovf || (dres[a].q > dipole_limit_r)) ? dipole_limit_r : dres[a].q;
    assign mm   = (dside_r[DIV_LAT-1].gated || dside_r[DIV_LAT-1].fz) ? '0 : qsel;
    assign sm_nxt.m[a] = dside_r[DIV_LAT-1].cneg[a] ?
                         DIPOLE_W'(-$signed({1'b0, mm})) : DIPOLE_W'({1'b0, mm});

    always_ff @(posedge clk) begin
      bm_r[a] <= $signed(dside_r[DIV_LAT-1].b[a]);
    end

    // Torque m x B: products, difference, then magnitude and rounding offset.
    always_ff @(posedge clk) begin
      ta_r[a]  <= $signed(sm_r.m[J]) * bm_r[K];
      tb_r[a]  <= $signed(sm_r.m[K]) * bm_r[J];
    end

    assign t_nxt = ta_r[a] - tb_r[a];

    always_ff @(posedge clk) begin
      t_r[a] <= t_nxt;
    end

    assign tmag = (t_r[a] < 0) ? 36'(-t_r[a]) : 36'(t_r[a]);

    always_ff @(posedge clk) begin
      y_r[a]   <= (Y_W'(tmag) << DEN_SHIFT) + Y_W'(ROUND_HALF);
      ts3_r[a] <= (t_r[a] < 0);
    end

    mmd_torque_scale u_scl (
      .clk (clk),
      .y   (y_r[a]),
      .q   (tq[a])
    );

    // Output register.
    always_ff @(posedge clk) begin
      torque_r[a] <= tsd_r[SCALE_LAT-1][a] ?
                     -$signed({{(TORQUE_W-QT_W){1'b0}}, tq[a]}) :
                     $signed({{(TORQUE_W-QT_W){1'b0}}, tq[a]});
    end
  end

  assign dside_nxt.gated = gated8_r;
  assign dside_nxt.fz    = fz8_r;
  assign sm_nxt.gated    = dside_r[DIV_LAT-1].gated;
  assign sm_nxt.fz       = dside_r[DIV_LAT-1].fz;

  // Side data delay lines alongside the divider and the torque stages.
  always_ff @(posedge clk) begin
    dside_r[0] <= dside_nxt;
    for (int s = 1; s < DIV_LAT; s++) begin
      dside_r[s] <= dside_r[s-1];
    end
    sm_r      <= sm_nxt;
    tail_r[0] <= sm_r;
    for (int s = 1; s < TAIL_LAT; s++) begin
      tail_r[s] <= tail_r[s-1];
    end
    tsd_r[0] <= ts3_r;
    for (int s = 1; s < SCALE_LAT; s++) begin
      tsd_r[s] <= tsd_r[s-1];
    end
  end

  // Flags and dipoles of the result beat.
  logic                      gated_out_r, fz_out_r;
  logic signed [DIPOLE_W-1:0] dip_r [AXES];

  always_ff @(posedge clk) begin
    gated_out_r <= tail_r[TAIL_LAT-1].gated & ~tail_r[TAIL_LAT-1].fz;
    fz_out_r    <= tail_r[TAIL_LAT-1].fz;
    for (int i = 0; i < AXES; i++) begin
      dip_r[i] <= $signed(tail_r[TAIL_LAT-1].m[i]);
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_torque_x   = torque_r[0];
  assign out_torque_y   = torque_r[1];
  assign out_torque_z   = torque_r[2];
  assign out_dipole_x   = dip_r[0];
  assign out_dipole_y   = dip_r[1];
  assign out_dipole_z   = dip_r[2];
  assign out_gated_off  = gated_out_r;
  assign out_field_zero = fz_out_r;

  // A zero field leaves nothing but the flag.
  a_fz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_zero |->
      out_torque_x == '0 && out_torque_y == '0 && out_torque_z == '0 &&
      out_dipole_x == '0 && out_dipole_y == '0 && out_dipole_z == '0)
    else $error("field_zero beat carries nonzero torque or dipole");

  // A gated beat commands no dipole and no torque.
  a_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gated_off |->
      out_torque_x == '0 && out_torque_y == '0 && out_torque_z == '0 &&
      out_dipole_x == '0 && out_dipole_y == '0 && out_dipole_z == '0)
    else $error("gated beat carries nonzero torque or dipole");

  // The two flags never show together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_gated_off && out_field_zero))
    else $error("gated_off and field_zero both set");

  // Reset flushes every beat in flight.
  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire
